/* src/bfd_pkg.sv */
// shared types, constants and register map for the bounding box follow drive control
`timescale 1ns / 1ps

package bfd_pkg;

    localparam int FRAME_PIXELS_WIDE_DEFAULT = 640;

    // offset in half pixels covers 2*1023 + 1023 - 640 down to -640 at the default frame width
    localparam int DX_W = 13;
    localparam int MAG_W = DX_W - 1;

    localparam int Q_ONE = 16384;
    localparam int RATIO_MAX = 131072;

    // quotient bits of the area ratio and divider split
    localparam int QBITS = 18;
    localparam int DIV_STEPS = 2;
    localparam int DIV_STAGES = QBITS / DIV_STEPS;

    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    localparam logic [2:0] REG_GOAL_AREA = 3'd0;
    localparam logic [2:0] REG_DEADZONE_HALF_PX = 3'd1;
    localparam logic [2:0] REG_YAW_GAIN = 3'd2;
    localparam logic [2:0] REG_DISTANCE_GAIN = 3'd3;
    localparam logic [2:0] REG_SIZE_BAND = 3'd4;
    localparam logic [2:0] REG_SPEED_CAP = 3'd5;
    localparam logic [2:0] REG_TURN_CAP = 3'd6;

    typedef struct packed {
        logic [9:0] box_left;
        logic [9:0] box_width;
        logic [9:0] box_height;
    } box_word_t;

    typedef struct packed {
        logic signed [15:0] left_wheel;
        logic signed [15:0] right_wheel;
        logic               no_target;
    } cmd_word_t;

    typedef struct packed {
        logic [18:0] goal_area;
        logic [10:0] deadzone_half_px;
        logic [19:0] yaw_gain;
        logic [15:0] distance_gain;
        logic [14:0] size_band;
        logic [14:0] speed_cap;
        logic [14:0] turn_cap;
    } cfg_t;

    typedef struct packed {
        logic               no_target;
        logic signed [15:0] omega;
        logic               ovf;
        logic [18:0]        rem;
        logic [QBITS-1:0]   qn;
    } div_word_t;

endpackage

/* src/bfd_front.sv */
// input stages: center offset, box area, yaw command and divider setup
`timescale 1ns / 1ps

module bfd_front
    import bfd_pkg::*;
#(
    parameter int FRAME_PIXELS_WIDE = FRAME_PIXELS_WIDE_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        adv,
    input  logic        in_vld,
    input  box_word_t   box,
    input  cfg_t        cfg,
    input  logic [18:0] div_den,
    output logic        out_vld,
    output div_word_t   out_word
);

    localparam logic signed [DX_W-1:0] FRAME_OFS = DX_W'(FRAME_PIXELS_WIDE);

    logic signed [DX_W-1:0] dx;
    logic [DX_W-1:0]        dx_abs;

    logic             s1_vld_reg;
    logic [MAG_W-1:0] s1_mag_reg;
    logic             s1_neg_reg;
    logic [19:0]      s1_prod_reg;
    logic             s1_nt_reg;

    logic             s2_vld_reg;
    logic [31:0]      s2_ygp_reg;
    logic             s2_neg_reg;
    logic             s2_on_reg;
    logic             s2_nt_reg;
    logic             s2_ovf_reg;
    logic [18:0]      s2_rem_reg;
    logic [QBITS-1:0] s2_qn_reg;

    logic               s3_vld_reg;
    div_word_t          s3_word_reg;
    div_word_t          s3_word_next;
    logic [32:0]        yaw_round;
    logic [22:0]        yaw_mag;
    logic [14:0]        yaw_lim;

    always_comb
    begin
        dx = $signed({2'b0, box.box_left, 1'b0}) + $signed({3'b0, box.box_width}) - FRAME_OFS;
        dx_abs = dx[DX_W-1] ? DX_W'(-dx) : DX_W'(dx);
    end

    always_comb
    begin
        yaw_round = {1'b0, s2_ygp_reg} + 33'd512;
        yaw_mag = yaw_round[32:10];
        yaw_lim = (yaw_mag > {8'b0, cfg.turn_cap}) ? cfg.turn_cap : yaw_mag[14:0];
        s3_word_next.no_target = s2_nt_reg;
        s3_word_next.ovf = s2_ovf_reg;
        s3_word_next.rem = s2_rem_reg;
        s3_word_next.qn = s2_qn_reg;
        if (!s2_on_reg)
        begin
            s3_word_next.omega = '0;
        end
        else if (s2_neg_reg)
        begin
            s3_word_next.omega = -$signed({1'b0, yaw_lim});
        end
        else
        begin
            s3_word_next.omega = $signed({1'b0, yaw_lim});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg <= in_vld;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_mag_reg <= dx_abs[MAG_W-1:0];
            s1_neg_reg <= dx[DX_W-1];
            s1_prod_reg <= box.box_width * box.box_height;
            s1_nt_reg <= (box.box_width == '0) || (box.box_height == '0);

            s2_ygp_reg <= s1_mag_reg * cfg.yaw_gain;
            s2_neg_reg <= s1_neg_reg;
            s2_on_reg <= {1'b0, s1_mag_reg} > {2'b0, cfg.deadzone_half_px};
            s2_nt_reg <= s1_nt_reg;
            s2_ovf_reg <= {3'b0, s1_prod_reg} >= {div_den, 4'b0};
            s2_rem_reg <= {3'b0, s1_prod_reg[19:4]};
            s2_qn_reg <= {s1_prod_reg[3:0], 14'b0};

            s3_word_reg <= s3_word_next;
        end
    end

    assign out_vld = s3_vld_reg;
    assign out_word = s3_word_reg;

endmodule

/* src/bfd_div_stage.sv */
// one stage of the restoring area ratio divider
`timescale 1ns / 1ps

module bfd_div_stage
    import bfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        adv,
    input  logic        in_vld,
    input  div_word_t   in_word,
    input  logic [18:0] div_den,
    output logic        out_vld,
    output div_word_t   out_word
);

    logic      vld_reg;
    div_word_t word_reg;
    div_word_t word_next;

    always_comb
    begin
        logic [18:0]      r;
        logic [QBITS-1:0] q;
        logic [19:0]      t;
        r = in_word.rem;
        q = in_word.qn;
        t = '0;
        // dividend bits shift out of the top while quotient bits shift in
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            t = {r, q[QBITS-1]};
            q = {q[QBITS-2:0], 1'b0};
            if (t >= {1'b0, div_den})
            begin
                t = t - {1'b0, div_den};
                q[0] = 1'b1;
            end
            r = t[18:0];
        end
        word_next = in_word;
        word_next.rem = r;
        word_next.qn = q;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            word_reg <= word_next;
        end
    end

    assign out_vld = vld_reg;
    assign out_word = word_reg;

endmodule

/* src/bfd_back.sv */
// output stages: ratio band, speed command and wheel mixing
`timescale 1ns / 1ps

module bfd_back
    import bfd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      adv,
    input  logic      in_vld,
    input  div_word_t in_word,
    input  cfg_t      cfg,
    output logic      out_vld,
    output cmd_word_t out_word
);

    localparam logic signed [17:0] WHEEL_LIM = 18'sd16384;

    logic [QBITS-1:0] ratio;
    logic             fwd;
    logic             rev;
    logic [16:0]      err;
    logic [17:0]      diff_lo;
    logic [17:0]      diff_hi;

    logic               a_vld_reg;
    logic [16:0]        a_err_reg;
    logic               a_rev_reg;
    logic signed [15:0] a_omega_reg;
    logic               a_nt_reg;

    logic               b_vld_reg;
    logic [32:0]        b_prod_reg;
    logic               b_rev_reg;
    logic signed [15:0] b_omega_reg;
    logic               b_nt_reg;

    logic               c_vld_reg;
    cmd_word_t          c_word_reg;
    cmd_word_t          c_word_next;

    logic [33:0]        spd_round;
    logic [19:0]        spd_mag;
    logic [14:0]        spd_lim;
    logic signed [17:0] spd;
    logic signed [17:0] om;
    logic signed [17:0] lsum;
    logic signed [17:0] rsum;
    logic signed [17:0] lclp;
    logic signed [17:0] rclp;

    always_comb
    begin
        ratio = (in_word.ovf || (in_word.qn > QBITS'(RATIO_MAX))) ? QBITS'(RATIO_MAX)
                                                                 : in_word.qn;
        fwd = ({1'b0, ratio} + {4'b0, cfg.size_band}) < 19'(Q_ONE);
        rev = ratio > ({3'b0, cfg.size_band} + 18'(Q_ONE));
        diff_lo = 18'(Q_ONE) - ratio;
        diff_hi = ratio - 18'(Q_ONE);
        if (fwd)
        begin
            err = diff_lo[16:0];
        end
        else if (rev)
        begin
            err = diff_hi[16:0];
        end
        else
        begin
            err = '0;
        end
    end

    always_comb
    begin
        spd_round = {1'b0, b_prod_reg} + 34'd8192;
        spd_mag = spd_round[33:14];
        spd_lim = (spd_mag > {5'b0, cfg.speed_cap}) ? cfg.speed_cap : spd_mag[14:0];
        spd = b_rev_reg ? -$signed({3'b0, spd_lim}) : $signed({3'b0, spd_lim});
        om = {{2{b_omega_reg[15]}}, b_omega_reg};
        lsum = spd - om;
        rsum = spd + om;
        if (lsum > WHEEL_LIM)
        begin
            lclp = WHEEL_LIM;
        end
        else if (lsum < -WHEEL_LIM)
        begin
            lclp = -WHEEL_LIM;
        end
        else
        begin
            lclp = lsum;
        end
        if (rsum > WHEEL_LIM)
        begin
            rclp = WHEEL_LIM;
        end
        else if (rsum < -WHEEL_LIM)
        begin
            rclp = -WHEEL_LIM;
        end
        else
        begin
            rclp = rsum;
        end
        c_word_next.no_target = b_nt_reg;
        c_word_next.left_wheel = b_nt_reg ? '0 : lclp[15:0];
        c_word_next.right_wheel = b_nt_reg ? '0 : rclp[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_vld_reg <= in_vld;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_err_reg <= err;
            a_rev_reg <= rev;
            a_omega_reg <= in_word.omega;
            a_nt_reg <= in_word.no_target;

            b_prod_reg <= cfg.distance_gain * a_err_reg;
            b_rev_reg <= a_rev_reg;
            b_omega_reg <= a_omega_reg;
            b_nt_reg <= a_nt_reg;

            c_word_reg <= c_word_next;
        end
    end

    assign out_vld = c_vld_reg;
    assign out_word = c_word_reg;

endmodule

/* src/bbox_follow_drive_control.sv */
// top level: register file, pipeline chain and output handshake
//
// Takes one bounding box word per cycle on the box channel (box_valid,
// box_ready, box) and returns one wheel command word on the cmd channel
// (cmd_valid, cmd_ready, cmd) for every box, in order.
// Between acceptance and cmd_valid lie three input stages (offset and
// area, yaw and divider setup, yaw clamp), nine divider stages of two
// quotient bits each, and three output stages (ratio band, speed
// multiply, wheel mix into the output register).
// Throughput is one word per cycle; the whole pipeline moves together and
// box_ready is high whenever the output register is empty or being taken.
// When the receiver holds cmd_ready low with cmd_valid high, every stage
// holds its contents and box_ready drops until the word is taken.
// Reset empties the pipeline and loads the register defaults. Registers
// sit on an APB port at byte offsets 4*i; the user must write them only
// while no word is in flight, which the block itself does not enforce.
`timescale 1ns / 1ps

module bbox_follow_drive_control
    import bfd_pkg::*;
#(
    parameter int FRAME_PIXELS_WIDE = FRAME_PIXELS_WIDE_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    input  logic               box_valid,
    output logic               box_ready,
    input  box_word_t          box,
    output logic               cmd_valid,
    input  logic               cmd_ready,
    output cmd_word_t          cmd
);

    cfg_t        cfg_reg;
    logic [18:0] div_den;
    logic        adv;
    logic        wr_en;

    logic      div_vld [0:DIV_STAGES];
    div_word_t div_word [0:DIV_STAGES];

    assign pready = 1'b1;
    assign wr_en = psel && penable && pwrite;
    assign div_den = (cfg_reg.goal_area == '0) ? 19'd1 : cfg_reg.goal_area;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.goal_area <= 19'd19200;
            cfg_reg.deadzone_half_px <= 11'd102;
            cfg_reg.yaw_gain <= 20'd25166;
            cfg_reg.distance_gain <= 16'd13107;
            cfg_reg.size_band <= 15'd2458;
            cfg_reg.speed_cap <= 15'd16384;
            cfg_reg.turn_cap <= 15'd13107;
        end
        else if (wr_en)
        begin
            case (paddr[4:2])
                REG_GOAL_AREA:        cfg_reg.goal_area <= pwdata[18:0];
                REG_DEADZONE_HALF_PX: cfg_reg.deadzone_half_px <= pwdata[10:0];
                REG_YAW_GAIN:         cfg_reg.yaw_gain <= pwdata[19:0];
                REG_DISTANCE_GAIN:    cfg_reg.distance_gain <= pwdata[15:0];
                REG_SIZE_BAND:        cfg_reg.size_band <= pwdata[14:0];
                REG_SPEED_CAP:        cfg_reg.speed_cap <= pwdata[14:0];
                REG_TURN_CAP:         cfg_reg.turn_cap <= pwdata[14:0];
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_GOAL_AREA:        prdata = PDATA_W'(cfg_reg.goal_area);
            REG_DEADZONE_HALF_PX: prdata = PDATA_W'(cfg_reg.deadzone_half_px);
            REG_YAW_GAIN:         prdata = PDATA_W'(cfg_reg.yaw_gain);
            REG_DISTANCE_GAIN:    prdata = PDATA_W'(cfg_reg.distance_gain);
            REG_SIZE_BAND:        prdata = PDATA_W'(cfg_reg.size_band);
            REG_SPEED_CAP:        prdata = PDATA_W'(cfg_reg.speed_cap);
            REG_TURN_CAP:         prdata = PDATA_W'(cfg_reg.turn_cap);
            default:              prdata = '0;
        endcase
    end

    // whole pipeline advances unless a finished word is held at the output
    assign adv = !cmd_valid || cmd_ready;
    assign box_ready = adv;

    bfd_front #(
        .FRAME_PIXELS_WIDE(FRAME_PIXELS_WIDE)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_vld   (box_valid),
        .box      (box),
        .cfg      (cfg_reg),
        .div_den  (div_den),
        .out_vld  (div_vld[0]),
        .out_word (div_word[0])
    );

    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_div
        bfd_div_stage u_div (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (adv),
            .in_vld   (div_vld[g]),
            .in_word  (div_word[g]),
            .div_den  (div_den),
            .out_vld  (div_vld[g+1]),
            .out_word (div_word[g+1])
        );
    end

    bfd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_vld   (div_vld[DIV_STAGES]),
        .in_word  (div_word[DIV_STAGES]),
        .cfg      (cfg_reg),
        .out_vld  (cmd_valid),
        .out_word (cmd)
    );

    a_no_target_zero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd.no_target |-> cmd.left_wheel == '0 && cmd.right_wheel == '0)
        else $error("no target word with nonzero wheel command");

    a_wheel_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid |-> cmd.left_wheel <= 16'sd16384 && cmd.left_wheel >= -16'sd16384
            && cmd.right_wheel <= 16'sd16384 && cmd.right_wheel >= -16'sd16384)
        else $error("wheel command outside unit range");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_ready |-> !box_ready)
        else $error("input taken while output word is held");

endmodule

/* verif/tb.sv */
// testbench: directed and random boxes and register settings checked against a predictor
`timescale 1ns / 1ps

module tb;
    import bfd_pkg::*;

    localparam int FRAME_W = FRAME_PIXELS_WIDE_DEFAULT;
    localparam int PIPE_DRAIN = 24;
    localparam int LIMIT_CYCLES = 400000;
    localparam int RANDOM_PER_PHASE = 85;
    localparam int RANDOM_CFG_PHASES = 4;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic              pready;
    logic              box_valid = 1'b0;
    logic              box_ready;
    box_word_t         box = '0;
    logic              cmd_valid;
    logic              cmd_ready = 1'b0;
    cmd_word_t         cmd;

    box_word_t pending_boxes[$];
    cmd_word_t cmd_expect[$];
    cfg_t      model_cfg;

    logic box_acc = 1'b0;
    int   err_count = 0;
    int   cmds_taken = 0;
    int   cycle_count = 0;

    int burst_left = 0;
    int gap_left = 0;

    int  hold_left = 0;
    bit  long_hold_done = 1'b0;
    int  rx_mode = 0;
    int  rx_seg_left = 0;

    bbox_follow_drive_control #(
        .FRAME_PIXELS_WIDE(FRAME_W)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .box_valid(box_valid),
        .box_ready(box_ready),
        .box(box),
        .cmd_valid(cmd_valid),
        .cmd_ready(cmd_ready),
        .cmd(cmd)
    );

    always #6 clk = ~clk;

    function automatic longint limit_abs(longint v, longint lim);
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    function automatic cmd_word_t wheel_cmd(box_word_t b, cfg_t c);
        longint lft, wid, hgt, dx, mag, yaw, spd, ratio, area_ref;
        longint dz, yg, dg, tol, lin_max, ang_max, lw, rw;
        cmd_word_t r;
        lft = b.box_left;
        wid = b.box_width;
        hgt = b.box_height;
        dz = c.deadzone_half_px;
        yg = c.yaw_gain;
        dg = c.distance_gain;
        tol = c.size_band;
        lin_max = c.speed_cap;
        ang_max = c.turn_cap;
        area_ref = c.goal_area;
        r = '0;
        if (wid == 0 || hgt == 0)
        begin
            r.no_target = 1'b1;
            return r;
        end
        dx = 2 * lft + wid - FRAME_W;
        mag = (dx < 0) ? -dx : dx;
        yaw = 0;
        if (mag > dz)
        begin
            yaw = (mag * yg + 512) >>> 10;
            if (dx < 0)
                yaw = -yaw;
        end
        yaw = limit_abs(yaw, ang_max);
        if (area_ref == 0)
            area_ref = 1;
        ratio = ((wid * hgt) <<< 14) / area_ref;
        if (ratio > RATIO_MAX)
            ratio = RATIO_MAX;
        spd = 0;
        if (ratio < Q_ONE - tol)
            spd = (dg * (Q_ONE - ratio) + 8192) >>> 14;
        else if (ratio > Q_ONE + tol)
            spd = -((dg * (ratio - Q_ONE) + 8192) >>> 14);
        spd = limit_abs(spd, lin_max);
        lw = limit_abs(spd - yaw, Q_ONE);
        rw = limit_abs(spd + yaw, Q_ONE);
        r.left_wheel = lw[15:0];
        r.right_wheel = rw[15:0];
        return r;
    endfunction

    function automatic box_word_t mk_box(int l, int w, int h);
        box_word_t b;
        b.box_left = l[9:0];
        b.box_width = w[9:0];
        b.box_height = h[9:0];
        return b;
    endfunction

    function automatic int clip(int v, int lo, int hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // mostly plausible detections, some noise and lost targets
    function automatic box_word_t rand_box(cfg_t c);
        int kind, l, w, h, ra;
        kind = $urandom_range(0, 9);
        ra = (c.goal_area == 0) ? 1 : int'(c.goal_area);
        l = $urandom_range(0, 1023);
        w = $urandom_range(0, 1023);
        h = $urandom_range(0, 1023);
        case (kind)
            0:
            begin
                if ($urandom_range(0, 1))
                    w = 0;
                else
                    h = 0;
                if ($urandom_range(0, 3) == 0)
                begin
                    w = 0;
                    h = 0;
                end
            end
            1: ;
            2, 3, 4:
            begin
                w = $urandom_range(8, 400);
                h = clip(ra / w + $urandom_range(0, 40) - 20, 1, 1023);
                l = clip((FRAME_W - w) / 2 + $urandom_range(0, 300) - 150, 0, 1023);
            end
            5, 6:
            begin
                w = $urandom_range(1, 300);
                h = $urandom_range(1, 300);
                l = clip((FRAME_W - w) / 2 + $urandom_range(0, 120) - 60, 0, 1023);
            end
            default:
            begin
                w = $urandom_range(1, 400);
                h = $urandom_range(1, 400);
            end
        endcase
        return mk_box(l, w, h);
    endfunction

    function automatic int pick(int lo, int hi, int full_max);
        if ($urandom_range(0, 1))
            return $urandom_range(lo, hi);
        return $urandom_range(0, full_max);
    endfunction

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_GOAL_AREA: model_cfg.goal_area = val[18:0];
            REG_DEADZONE_HALF_PX: model_cfg.deadzone_half_px = val[10:0];
            REG_YAW_GAIN: model_cfg.yaw_gain = val[19:0];
            REG_DISTANCE_GAIN: model_cfg.distance_gain = val[15:0];
            REG_SIZE_BAND: model_cfg.size_band = val[14:0];
            REG_SPEED_CAP: model_cfg.speed_cap = val[14:0];
            REG_TURN_CAP: model_cfg.turn_cap = val[14:0];
            default: ;
        endcase
    endtask

    task automatic load_cfg(input cfg_t c);
        reg_write(REG_GOAL_AREA, 32'(c.goal_area));
        reg_write(REG_DEADZONE_HALF_PX, 32'(c.deadzone_half_px));
        reg_write(REG_YAW_GAIN, 32'(c.yaw_gain));
        reg_write(REG_DISTANCE_GAIN, 32'(c.distance_gain));
        reg_write(REG_SIZE_BAND, 32'(c.size_band));
        reg_write(REG_SPEED_CAP, 32'(c.speed_cap));
        reg_write(REG_TURN_CAP, 32'(c.turn_cap));
    endtask

    task automatic wait_idle();
        while (pending_boxes.size() != 0 || box_valid || cmd_expect.size() != 0)
            @(negedge clk);
        repeat (PIPE_DRAIN) @(negedge clk);
    endtask

    task automatic queue_random(input int n);
        repeat (n) pending_boxes.push_back(rand_box(model_cfg));
    endtask

    // sender: bursts and gaps
    always @(negedge clk)
    begin
        if (!rst_n)
            box_valid <= 1'b0;
        else if (!box_valid || box_acc)
        begin
            if (gap_left > 0)
            begin
                box_valid <= 1'b0;
                gap_left = gap_left - 1;
            end
            else if (pending_boxes.size() != 0)
            begin
                box <= pending_boxes.pop_front();
                box_valid <= 1'b1;
                if (burst_left > 0)
                    burst_left = burst_left - 1;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            else
                box_valid <= 1'b0;
        end
    end

    // receiver: stall pattern with one long hold-off
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            cmd_ready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else if (!long_hold_done && cmds_taken >= 30)
        begin
            cmd_ready <= 1'b0;
            hold_left = 80;
            long_hold_done = 1'b1;
        end
        else
        begin
            if (rx_seg_left == 0)
            begin
                rx_mode = $urandom_range(0, 3);
                rx_seg_left = $urandom_range(10, 80);
            end
            rx_seg_left = rx_seg_left - 1;
            case (rx_mode)
                0: cmd_ready <= 1'b1;
                1: cmd_ready <= ($urandom_range(0, 3) != 0);
                2: cmd_ready <= $urandom_range(0, 1);
                default: cmd_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // monitor and checker
    always @(posedge clk)
    begin
        cmd_word_t want;
        box_acc <= rst_n && box_valid && box_ready;
        if (rst_n)
        begin
            if (box_valid && box_ready)
                cmd_expect.push_back(wheel_cmd(box, model_cfg));
            if (cmd_valid && cmd_ready)
            begin
                cmds_taken = cmds_taken + 1;
                if (cmd_expect.size() == 0)
                begin
                    if (err_count < 10)
                        $display("unexpected cmd word: %0d %0d %0d",
                                 cmd.left_wheel, cmd.right_wheel, cmd.no_target);
                    err_count = err_count + 1;
                end
                else
                begin
                    want = cmd_expect.pop_front();
                    if (cmd.left_wheel !== want.left_wheel ||
                        cmd.right_wheel !== want.right_wheel ||
                        cmd.no_target !== want.no_target)
                    begin
                        if (err_count < 10)
                            $display("cmd mismatch at word %0d: exp %0d %0d %0d got %0d %0d %0d",
                                     cmds_taken, want.left_wheel, want.right_wheel,
                                     want.no_target, cmd.left_wheel, cmd.right_wheel,
                                     cmd.no_target);
                        err_count = err_count + 1;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        cfg_t c;
        model_cfg.goal_area = 19'd19200;
        model_cfg.deadzone_half_px = 11'd102;
        model_cfg.yaw_gain = 20'd25166;
        model_cfg.distance_gain = 16'd13107;
        model_cfg.size_band = 15'd2458;
        model_cfg.speed_cap = 15'd16384;
        model_cfg.turn_cap = 15'd13107;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed boxes at reset settings
        pending_boxes.push_back(mk_box(0, 0, 0));
        pending_boxes.push_back(mk_box(1023, 0, 1023));
        pending_boxes.push_back(mk_box(512, 1023, 0));
        pending_boxes.push_back(mk_box(0, 1, 1));
        pending_boxes.push_back(mk_box(1023, 1023, 1023));
        pending_boxes.push_back(mk_box(0, 1023, 1023));
        pending_boxes.push_back(mk_box(1023, 1, 1));
        pending_boxes.push_back(mk_box(270, 100, 100));
        pending_boxes.push_back(mk_box(321, 100, 192));
        pending_boxes.push_back(mk_box(321, 101, 192));
        pending_boxes.push_back(mk_box(219, 100, 192));
        pending_boxes.push_back(mk_box(218, 101, 150));
        pending_boxes.push_back(mk_box(240, 160, 120));
        pending_boxes.push_back(mk_box(260, 120, 136));
        pending_boxes.push_back(mk_box(260, 119, 137));
        pending_boxes.push_back(mk_box(260, 160, 138));
        pending_boxes.push_back(mk_box(260, 122, 181));
        pending_boxes.push_back(mk_box(0, 16, 8));
        pending_boxes.push_back(mk_box(1000, 1023, 1023));
        pending_boxes.push_back(mk_box(682, 341, 1023));
        pending_boxes.push_back(mk_box(341, 682, 341));
        queue_random(RANDOM_PER_PHASE);
        wait_idle();

        // all registers at zero, zero goal area acts as one
        c = '0;
        load_cfg(c);
        queue_random(RANDOM_PER_PHASE);
        wait_idle();

        // all registers at full scale
        c = '1;
        load_cfg(c);
        queue_random(RANDOM_PER_PHASE);
        wait_idle();

        // tiny goal area, high gains, no band, limits above one
        c.goal_area = 19'd1;
        c.deadzone_half_px = 11'd0;
        c.yaw_gain = 20'hFFFFF;
        c.distance_gain = 16'hFFFF;
        c.size_band = 15'd0;
        c.speed_cap = 15'h7FFF;
        c.turn_cap = 15'h7FFF;
        load_cfg(c);
        queue_random(RANDOM_PER_PHASE);
        wait_idle();

        repeat (RANDOM_CFG_PHASES)
        begin
            c.goal_area = 19'(pick(2000, 60000, 19'h7FFFF));
            c.deadzone_half_px = 11'(pick(0, 300, 11'h7FF));
            c.yaw_gain = 20'(pick(1000, 100000, 20'hFFFFF));
            c.distance_gain = 16'(pick(1000, 40000, 16'hFFFF));
            c.size_band = 15'(pick(0, 6000, 15'h7FFF));
            c.speed_cap = 15'(pick(4000, 16384, 15'h7FFF));
            c.turn_cap = 15'(pick(4000, 16384, 15'h7FFF));
            load_cfg(c);
            queue_random(RANDOM_PER_PHASE);
            wait_idle();
        end

        if (err_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* bbox_follow_drive_control.f */
src/bfd_pkg.sv
src/bfd_front.sv
src/bfd_div_stage.sv
src/bfd_back.sv
src/bbox_follow_drive_control.sv
verif/tb.sv
